[rtl/mer_pkg.sv]
// Shared widths, datapath command codes and status groups for the
// midpoint ellipse rasterizer. No dependencies; every other file but mer_in_if imports it.
`timescale 1ns / 1ps

package mer_pkg;

  // Field and register widths
  localparam int CX_W       = 12;  // center coordinate
  localparam int RAD_W      = 11;  // semi-axis
  localparam int COORD_W    = 13;  // emitted coordinate
  localparam int SPAN_W     = 12;  // span width
  localparam int Y_W        = 12;  // y offset, signed
  localparam int SQ_W       = 22;  // squared radius
  localparam int SLOPE_W    = 36;  // slope terms
  localparam int MUL_W      = 24;  // multiplier operand
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DEC_W      = PROD_W;  // decision variable
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_RADIUS_X    = 3'd2,
    CFG_RADIUS_Y    = 3'd3,
    CFG_FILLED_MODE = 3'd4
  } mer_cfg_idx_t;

  // Datapath operations, one per controller state
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_INIT_SQ,
    OP_INIT_LATCH,
    OP_INIT_PROD,
    OP_INIT_LOAD,
    OP_STEP_XY,
    OP_STEP_TERM,
    OP_STEP_DEC,
    OP_SW_MUL1,
    OP_SW_MUL2,
    OP_SW_SUB,
    OP_SW_ADD,
    OP_EMIT
  } mer_op_t;

  typedef struct packed {
    mer_op_t op;
    logic    last;
  } mer_cmd_t;

  typedef struct packed {
    logic radius_zero;
    logic region_two;
    logic sx_ge_sy;
    logic y_le_zero;
  } mer_stat_t;

endpackage

[rtl/mer_in_if.sv]
// Input channel of the ellipse rasterizer: valid/ready and the restart bit.
// No dependencies.
`timescale 1ns / 1ps

interface mer_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

[rtl/mer_out_if.sv]
// Result channel of the ellipse rasterizer: valid/ready and one coordinate set.
// Depends on mer_pkg for field widths.
`timescale 1ns / 1ps

interface mer_out_if;
  import mer_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_left;
  logic signed [COORD_W-1:0] x_right;
  logic signed [COORD_W-1:0] y_upper;
  logic signed [COORD_W-1:0] y_lower;
  logic        [SPAN_W-1:0]  span_width;
  logic                      last;

  modport source (output valid, output x_left, output x_right, output y_upper,
                  output y_lower, output span_width, output last, input ready);
  modport sink   (input valid, input x_left, input x_right, input y_upper,
                  input y_lower, input span_width, input last, output ready);
endinterface

[rtl/mer_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on mer_pkg for widths.
`timescale 1ns / 1ps

interface mer_cfg_if;
  import mer_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/midpoint_ellipse_rasterizer.sv]
// Midpoint ellipse rasterizer, one input word at a time. Restart with nonzero radii: INIT_SQ, INIT_LATCH,
// INIT_PROD, INIT_LOAD, then EMIT loads the output register; the next input waits for
// idle. Step: STEP_XY, STEP_TERM, STEP_DEC, then EMIT; the step that enters region two
// adds SW_MUL1, SW_MUL2, SW_SUB and SW_ADD for the product chain on the two shared
// multipliers. A held result stalls EMIT only when the next result is ready first.
// Synchronous active-low reset clears configuration, drops any word, leaves the walk idle.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer (
  input  logic      clk,
  input  logic      rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch,
  mer_cfg_if.sink   cfg_ch
);
  import mer_pkg::*;

  mer_cmd_t  cmd;
  mer_stat_t stat;

  // Registers accept a write every cycle
  assign cfg_ch.ready = 1'b1;

  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  mer_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_ch.valid && cfg_ch.ready),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .cmd        (cmd),
    .stat       (stat),
    .x_left     (out_ch.x_left),
    .x_right    (out_ch.x_right),
    .y_upper    (out_ch.y_upper),
    .y_lower    (out_ch.y_lower),
    .span_width (out_ch.span_width),
    .last       (out_ch.last)
  );

endmodule

[rtl/mer_datapath.sv]
// Datapath of the ellipse rasterizer: configuration registers, walk state,
// two shared multipliers and the output word register. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mer_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mer_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  mer_pkg::mer_cmd_t                  cmd,
  output mer_pkg::mer_stat_t                 stat,
  output logic signed [mer_pkg::COORD_W-1:0] x_left,
  output logic signed [mer_pkg::COORD_W-1:0] x_right,
  output logic signed [mer_pkg::COORD_W-1:0] y_upper,
  output logic signed [mer_pkg::COORD_W-1:0] y_lower,
  output logic [mer_pkg::SPAN_W-1:0]         span_width,
  output logic                               last
);
  import mer_pkg::*;

  // Configuration
  logic signed [CX_W-1:0]    cx_r, cy_r;
  logic [RAD_W-1:0]          rx_r, ry_r;
  logic                      fill_r;

  // Walk state
  logic [SQ_W-1:0]           rxsq_r, rysq_r;
  logic [PROD_W-1:0]         c_r;
  logic [RAD_W-1:0]          x_r;
  logic signed [Y_W-1:0]     y_r;
  logic signed [SLOPE_W-1:0] sx_r, sy_r;
  logic signed [DEC_W-1:0]   d_r, t_r;
  logic                      region_two_r;

  // Multipliers
  logic [PROD_W-1:0]         mul0_r, mul1_r;
  logic [MUL_W-1:0]          m0a, m0b, m1a, m1b;
  logic                      mul_en;

  // Output word
  logic signed [COORD_W-1:0] xl_r, xr_r, yu_r, yl_r;
  logic [SPAN_W-1:0]         span_r;
  logic                      last_r;

  logic signed [SLOPE_W-1:0] sx_inc, sy_dec, base;
  logic signed [DEC_W-1:0]   k_term, t_nxt;
  logic                      d_neg, d_pos, move_other;
  logic [RAD_W:0]            x_inc;
  logic signed [Y_W:0]       ym;
  logic [Y_W-1:0]            ym_abs;

  // Per-step increments of the slope terms
  assign sx_inc = $signed({{(SLOPE_W-SQ_W-1){1'b0}}, rysq_r, 1'b0});
  assign sy_dec = $signed({{(SLOPE_W-SQ_W-1){1'b0}}, rxsq_r, 1'b0});

  // Decide whether the minor axis also moves this step
  assign d_neg      = d_r[DEC_W-1];
  assign d_pos      = !d_neg && (d_r != '0);
  assign move_other = region_two_r ? !d_pos : !d_neg;

  // Decision increment from the freshly updated slope terms
  always_comb begin
    if (move_other) begin
      base = sx_r - sy_r;
    end else if (region_two_r) begin
      base = -sy_r;
    end else begin
      base = sx_r;
    end
    k_term = $signed({{(DEC_W-SQ_W){1'b0}}, region_two_r ? rxsq_r : rysq_r});
    t_nxt  = $signed({{(DEC_W-SLOPE_W){base[SLOPE_W-1]}}, base}) + k_term;
  end

  // Operands for the region switch products
  assign x_inc  = {1'b0, x_r} + 1'b1;
  assign ym     = {y_r[Y_W-1], y_r} - 1'b1;
  assign ym_abs = ym[Y_W] ? Y_W'(-ym) : Y_W'(ym);

  // Select multiplier operands
  always_comb begin
    m0a    = '0;
    m0b    = '0;
    m1a    = '0;
    m1b    = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_INIT_SQ: begin
        m0a = MUL_W'(rx_r);
        m0b = MUL_W'(rx_r);
        m1a = MUL_W'(ry_r);
        m1b = MUL_W'(ry_r);
      end
      OP_INIT_PROD: begin
        m0a = MUL_W'(rxsq_r);
        m0b = MUL_W'(ry_r);
        m1a = MUL_W'(rxsq_r);
        m1b = MUL_W'(rysq_r);
      end
      OP_SW_MUL1: begin
        m0a = MUL_W'(x_r);
        m0b = MUL_W'(x_inc);
        m1a = MUL_W'(ym_abs);
        m1b = MUL_W'(ym_abs);
      end
      OP_SW_MUL2: begin
        m0a = MUL_W'(rysq_r);
        m0b = mul0_r[MUL_W-1:0];
        m1a = MUL_W'(rxsq_r);
        m1b = mul1_r[MUL_W-1:0];
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul0_r <= m0a * m0b;
      mul1_r <= m1a * m1b;
    end
  end

  // Configuration, walk state and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r         <= '0;
      cy_r         <= '0;
      rx_r         <= '0;
      ry_r         <= '0;
      fill_r       <= 1'b0;
      region_two_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (mer_cfg_idx_t'(cfg_index))
          CFG_CENTER_X:    cx_r   <= $signed(cfg_data[CX_W-1:0]);
          CFG_CENTER_Y:    cy_r   <= $signed(cfg_data[CX_W-1:0]);
          CFG_RADIUS_X:    rx_r   <= cfg_data[RAD_W-1:0];
          CFG_RADIUS_Y:    ry_r   <= cfg_data[RAD_W-1:0];
          CFG_FILLED_MODE: fill_r <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (cmd.op)
        OP_INIT_LATCH: begin
          rxsq_r <= mul0_r[SQ_W-1:0];
          rysq_r <= mul1_r[SQ_W-1:0];
        end
        OP_INIT_LOAD: begin
          c_r          <= mul1_r;
          x_r          <= '0;
          y_r          <= $signed(Y_W'(ry_r));
          sx_r         <= '0;
          sy_r         <= $signed({mul0_r[SLOPE_W-2:0], 1'b0});
          d_r          <= $signed(DEC_W'(rysq_r)) - $signed(mul0_r)
                          + $signed(DEC_W'(rxsq_r >> 2));
          region_two_r <= 1'b0;
        end
        OP_STEP_XY: begin
          if (!region_two_r || move_other) begin
            x_r  <= x_r + 1'b1;
            sx_r <= sx_r + sx_inc;
          end
          if (region_two_r || move_other) begin
            y_r  <= y_r - 1'b1;
            sy_r <= sy_r - sy_dec;
          end
        end
        OP_STEP_TERM: t_r <= t_nxt;
        OP_STEP_DEC: begin
          d_r <= d_r + t_r;
          if (!region_two_r && (sx_r >= sy_r)) begin
            region_two_r <= 1'b1;
          end
        end
        OP_SW_SUB: d_r <= $signed(mul0_r - c_r);
        OP_SW_ADD: d_r <= d_r + $signed(mul1_r);
        OP_EMIT: begin
          xl_r   <= {cx_r[CX_W-1], cx_r} - COORD_W'(x_r);
          xr_r   <= {cx_r[CX_W-1], cx_r} + COORD_W'(x_r);
          yu_r   <= {cy_r[CX_W-1], cy_r} - {y_r[Y_W-1], y_r};
          yl_r   <= {cy_r[CX_W-1], cy_r} + {y_r[Y_W-1], y_r};
          span_r <= fill_r ? {x_r, 1'b1} : '0;
          last_r <= cmd.last;
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller
  assign stat.radius_zero = (rx_r == '0) || (ry_r == '0);
  assign stat.region_two  = region_two_r;
  assign stat.sx_ge_sy    = (sx_r >= sy_r);
  assign stat.y_le_zero   = y_r[Y_W-1] || (y_r == '0);

  assign x_left     = xl_r;
  assign x_right    = xr_r;
  assign y_upper    = yu_r;
  assign y_lower    = yl_r;
  assign span_width = span_r;
  assign last       = last_r;

endmodule

[rtl/mer_ctrl.sv]
// Controller of the ellipse rasterizer: sequences setup, step and region
// switch operations and owns the output valid flag. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_restart,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  mer_pkg::mer_stat_t stat,
  output mer_pkg::mer_cmd_t  cmd
);
  import mer_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_SQ,
    ST_INIT_LATCH,
    ST_INIT_PROD,
    ST_INIT_LOAD,
    ST_STEP_XY,
    ST_STEP_TERM,
    ST_STEP_DEC,
    ST_SW_MUL1,
    ST_SW_MUL2,
    ST_SW_SUB,
    ST_SW_ADD,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   walk_active_r, walk_active_nxt;
  logic   emit_last;

  assign emit_last = stat.region_two && stat.y_le_zero;

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    walk_active_nxt = walk_active_r;
    cmd.op          = OP_IDLE;
    cmd.last        = 1'b0;

    // drop the word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            if (stat.radius_zero) begin
              walk_active_nxt = 1'b0;
            end else begin
              state_nxt = ST_INIT_SQ;
            end
          end else if (walk_active_r) begin
            state_nxt = ST_STEP_XY;
          end
        end
      end
      ST_INIT_SQ: begin
        cmd.op    = OP_INIT_SQ;
        state_nxt = ST_INIT_LATCH;
      end
      ST_INIT_LATCH: begin
        cmd.op    = OP_INIT_LATCH;
        state_nxt = ST_INIT_PROD;
      end
      ST_INIT_PROD: begin
        cmd.op    = OP_INIT_PROD;
        state_nxt = ST_INIT_LOAD;
      end
      ST_INIT_LOAD: begin
        cmd.op          = OP_INIT_LOAD;
        walk_active_nxt = 1'b1;
        state_nxt       = ST_EMIT;
      end
      ST_STEP_XY: begin
        cmd.op    = OP_STEP_XY;
        state_nxt = ST_STEP_TERM;
      end
      ST_STEP_TERM: begin
        cmd.op    = OP_STEP_TERM;
        state_nxt = ST_STEP_DEC;
      end
      ST_STEP_DEC: begin
        cmd.op = OP_STEP_DEC;
        // enter region two: rebuild the decision from products
        if (!stat.region_two && stat.sx_ge_sy) begin
          state_nxt = ST_SW_MUL1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SW_MUL1: begin
        cmd.op    = OP_SW_MUL1;
        state_nxt = ST_SW_MUL2;
      end
      ST_SW_MUL2: begin
        cmd.op    = OP_SW_MUL2;
        state_nxt = ST_SW_SUB;
      end
      ST_SW_SUB: begin
        cmd.op    = OP_SW_SUB;
        state_nxt = ST_SW_ADD;
      end
      ST_SW_ADD: begin
        cmd.op    = OP_SW_ADD;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // load the output register when it is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          cmd.last      = emit_last;
          out_valid_nxt = 1'b1;
          if (emit_last) begin
            walk_active_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      walk_active_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      walk_active_r <= walk_active_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/mer_checker.sv]
// Port-level checks for the ellipse rasterizer and the bind that attaches
// them to the top level. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mer_pkg::COORD_W-1:0] x_left,
  input logic signed [mer_pkg::COORD_W-1:0] x_right,
  input logic signed [mer_pkg::COORD_W-1:0] y_upper,
  input logic signed [mer_pkg::COORD_W-1:0] y_lower,
  input logic [mer_pkg::SPAN_W-1:0]         span_width,
  input logic                               last
);
  import mer_pkg::*;

  logic [COORD_W-1:0] gap;

  assign gap = x_right - x_left + COORD_W'(1);

  // A stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(x_left) && $stable(x_right)
      && $stable(y_upper) && $stable(y_lower) && $stable(span_width) && $stable(last))
    else $error("result word changed while stalled");

  // No word appears the cycle after an input is taken
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A nonzero span runs from x_left to x_right, both included
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (span_width != '0) |-> gap == {1'b0, span_width})
    else $error("span width disagrees with edge points");

  // Reset clears the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .x_left     (out_ch.x_left),
  .x_right    (out_ch.x_right),
  .y_upper    (out_ch.y_upper),
  .y_lower    (out_ch.y_lower),
  .span_width (out_ch.span_width),
  .last       (out_ch.last)
);

[test/testbench.sv]
// Self-checking testbench for the midpoint ellipse rasterizer: directed table, then random walks.
// Depends on mer_pkg, the three channel interfaces and midpoint_ellipse_rasterizer under rtl/.
`timescale 1ns / 1ps

module testbench;
  import mer_pkg::*;

  localparam int WORD_TARGET   = 1950;  // input words accepted
  localparam int QUIET_TAIL    = 150;   // last words run without idling
  localparam int STALL_LIMIT   = 1000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 16;    // step plus region switch plus held result
  localparam int DRAIN_TAIL    = 24;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_left;
    logic signed [COORD_W-1:0] x_right;
    logic signed [COORD_W-1:0] y_upper;
    logic signed [COORD_W-1:0] y_lower;
    logic        [SPAN_W-1:0]  span_width;
    logic                      last;
  } coord_set_t;

  typedef enum logic [1:0] {
    ROW_SETUP,  // drain, then write all five registers
    ROW_WORD,   // send a word, expectation from the walk model
    ROW_TYPED   // send a word, expectation typed into the row
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic signed [CX_W-1:0]  cx;
    logic signed [CX_W-1:0]  cy;
    logic        [RAD_W-1:0] rx;
    logic        [RAD_W-1:0] ry;
    logic                    fill;
    logic                    restart;
    logic                    want_set;
    coord_set_t              want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mer_in_if  in_ch ();
  mer_out_if out_ch ();
  mer_cfg_if cfg_ch ();

  midpoint_ellipse_rasterizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register copy as last written
  logic signed [CX_W-1:0]  cx_r   = '0;
  logic signed [CX_W-1:0]  cy_r   = '0;
  logic        [RAD_W-1:0] rad_x  = '0;
  logic        [RAD_W-1:0] rad_y  = '0;
  logic                    fill_r = 1'b0;

  // Walk state, radii squared at restart
  longint pos_x = 0, pos_y = 0;
  longint grow_x = 0, grow_y = 0, dec_var = 0;
  longint rx_sq = 0, ry_sq = 0;
  bit     in_lower_arc = 1'b0;
  bit     walking = 1'b0;

  coord_set_t pending_sets[$];

  int  words_sent  = 0;
  int  sets_seen   = 0;
  int  walks_done  = 0;
  int  setups      = 0;
  int  mismatches  = 0;
  int  idle_cycles = 0;
  bit  gaps_on     = 1'b0;
  bit  stalls_on   = 1'b0;
  bit  quiet       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Build one coordinate set from the current offsets and registers
  function automatic coord_set_t emit_set(bit fin);
    coord_set_t s;
    s.x_left     = COORD_W'(longint'(cx_r) - pos_x);
    s.x_right    = COORD_W'(longint'(cx_r) + pos_x);
    s.y_upper    = COORD_W'(longint'(cy_r) - pos_y);
    s.y_lower    = COORD_W'(longint'(cy_r) + pos_y);
    s.span_width = fill_r ? SPAN_W'(2 * pos_x + 1) : '0;
    s.last       = fin;
    return s;
  endfunction

  // Advance the midpoint walk by one word; returns 1 when a set comes out
  function automatic bit ellipse_trace(bit restart, output coord_set_t res);
    longint ym;
    bit     fin;
    res = '0;
    if (restart) begin
      if (rad_x == 0 || rad_y == 0) begin
        walking = 1'b0;
        return 1'b0;
      end
      rx_sq = rad_x;
      rx_sq = rx_sq * rx_sq;
      ry_sq = rad_y;
      ry_sq = ry_sq * ry_sq;
      pos_x = 0;
      pos_y = rad_y;
      grow_x = 0;
      grow_y = 2 * rx_sq * pos_y;
      dec_var = ry_sq - rx_sq * pos_y + rx_sq / 4;
      in_lower_arc = 1'b0;
      walking = 1'b1;
      res = emit_set(1'b0);
      return 1'b1;
    end
    if (!walking) return 1'b0;

    if (!in_lower_arc) begin
      // Region one: x always moves, y moves when the midpoint is outside
      pos_x++;
      grow_x += 2 * ry_sq;
      if (dec_var < 0) begin
        dec_var += grow_x + ry_sq;
      end else begin
        pos_y--;
        grow_y -= 2 * rx_sq;
        dec_var += grow_x - grow_y + ry_sq;
      end
      if (grow_x >= grow_y) begin
        ym = pos_y - 1;
        in_lower_arc = 1'b1;
        dec_var = ry_sq * (pos_x * pos_x + pos_x) + rx_sq * ym * ym - rx_sq * ry_sq;
      end
    end else begin
      // Region two: y always moves, x moves when the midpoint is inside
      pos_y--;
      grow_y -= 2 * rx_sq;
      if (dec_var > 0) begin
        dec_var += rx_sq - grow_y;
      end else begin
        pos_x++;
        grow_x += 2 * ry_sq;
        dec_var += grow_x - grow_y + rx_sq;
      end
    end

    fin = in_lower_arc && pos_y <= 0;
    if (fin) begin
      walking = 1'b0;
      walks_done++;
    end
    res = emit_set(fin);
    return 1'b1;
  endfunction

  // Send one input word, then queue what it should produce
  task automatic push_word(bit restart, bit typed, bit want_set, coord_set_t want);
    coord_set_t predicted;
    bit         produced;
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    produced = ellipse_trace(restart, predicted);
    if (typed) produced = want_set;
    if (produced) begin
      pending_sets.push_back(typed ? want : predicted);
    end
  endtask

  // Hold input low until every set is back and the block has settled
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending_sets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(mer_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_CENTER_X:    cx_r   = val;
      CFG_CENTER_Y:    cy_r   = val;
      CFG_RADIUS_X:    rad_x  = val[RAD_W-1:0];
      CFG_RADIUS_Y:    rad_y  = val[RAD_W-1:0];
      CFG_FILLED_MODE: fill_r = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [4:0] mask, logic [CFG_DATA_W-1:0] cx, logic [CFG_DATA_W-1:0] cy,
                          logic [CFG_DATA_W-1:0] rx, logic [CFG_DATA_W-1:0] ry,
                          logic [CFG_DATA_W-1:0] fill);
    if (mask[0]) write_reg(CFG_CENTER_X, cx);
    if (mask[1]) write_reg(CFG_CENTER_Y, cy);
    if (mask[2]) write_reg(CFG_RADIUS_X, rx);
    if (mask[3]) write_reg(CFG_RADIUS_Y, ry);
    if (mask[4]) write_reg(CFG_FILLED_MODE, fill);
    cfg_ch.valid <= 1'b0;
    setups++;
  endtask

  function automatic stim_row_t row_setup(int cx, int cy, int rx, int ry, bit fill);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SETUP;
    r.cx   = CX_W'(cx);
    r.cy   = CX_W'(cy);
    r.rx   = RAD_W'(rx);
    r.ry   = RAD_W'(ry);
    r.fill = fill;
    return r;
  endfunction

  function automatic stim_row_t row_step(bit restart);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_WORD;
    r.restart = restart;
    return r;
  endfunction

  function automatic stim_row_t row_check(bit restart, bit want_set, int xl, int xr, int yu,
                                          int yl, int span, bit last);
    stim_row_t r;
    r = '0;
    r.kind                 = ROW_TYPED;
    r.restart              = restart;
    r.want_set             = want_set;
    r.want.x_left          = COORD_W'(xl);
    r.want.x_right         = COORD_W'(xr);
    r.want.y_upper         = COORD_W'(yu);
    r.want.y_lower         = COORD_W'(yl);
    r.want.span_width      = SPAN_W'(span);
    r.want.last            = last;
    return r;
  endfunction

  // Mostly small radii so walks finish; now and then zero, full or any size
  function automatic logic [RAD_W-1:0] pick_radius();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return RAD_W'($urandom_range(1, 2047));
    return RAD_W'($urandom_range(1, 12));
  endfunction

  // Result side: random ready bursts, none in the quiet tail
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && !quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted set with the oldest expectation
  always @(posedge clk) begin : check_results
    coord_set_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sets_seen++;
      if (pending_sets.size() == 0) begin
        flag_mismatch("coordinate set with none expected");
      end else begin
        want = pending_sets.pop_front();
        if (out_ch.x_left !== want.x_left)
          flag_mismatch($sformatf("x_left %0d, want %0d", out_ch.x_left, want.x_left));
        if (out_ch.x_right !== want.x_right)
          flag_mismatch($sformatf("x_right %0d, want %0d", out_ch.x_right, want.x_right));
        if (out_ch.y_upper !== want.y_upper)
          flag_mismatch($sformatf("y_upper %0d, want %0d", out_ch.y_upper, want.y_upper));
        if (out_ch.y_lower !== want.y_lower)
          flag_mismatch($sformatf("y_lower %0d, want %0d", out_ch.y_lower, want.y_lower));
        if (out_ch.span_width !== want.span_width)
          flag_mismatch($sformatf("span_width %0d, want %0d", out_ch.span_width,
                                  want.span_width));
        if (out_ch.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", out_ch.last, want.last));
      end
    end
  end

  // Watchdog: end the run when no channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d sets outstanding",
               idle_cycles, pending_sets.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t        directed[$];
    coord_set_t       no_set;
    logic [RAD_W-1:0] rx_pick;
    logic [RAD_W-1:0] ry_pick;
    logic [4:0]       mask;
    int               cap;
    int               n;
    int               wait_left;

    no_set = '0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.restart  <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_CENTER_X;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: idle and zero-radius words, unit circle, extremes, mid-walk changes
    directed.push_back(row_check(1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(row_check(1'b1, 1'b0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(row_setup(0, 0, 1, 1, 1'b1));
    directed.push_back(row_check(1'b1, 1'b1, 0, 0, -1, 1, 1, 1'b0));
    directed.push_back(row_check(1'b0, 1'b1, -1, 1, 0, 0, 3, 1'b1));
    directed.push_back(row_check(1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(row_setup(2047, -2048, 2047, 2047, 1'b1));
    directed.push_back(row_check(1'b1, 1'b1, 2047, 2047, -4095, -1, 1, 1'b0));
    repeat (6) directed.push_back(row_step(1'b0));
    directed.push_back(row_setup(-2048, 2047, 2047, 1, 1'b0));
    directed.push_back(row_check(1'b1, 1'b1, -2048, -2048, 2046, 2048, 0, 1'b0));
    repeat (3) directed.push_back(row_step(1'b0));
    // new center and mode apply at once, new radii wait for a restart
    directed.push_back(row_setup(100, -50, 1, 2047, 1'b1));
    repeat (3) directed.push_back(row_step(1'b0));
    directed.push_back(row_setup(5, 5, 0, 5, 1'b0));
    directed.push_back(row_check(1'b1, 1'b0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(row_check(1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(row_setup(5, 5, 3, 0, 1'b1));
    directed.push_back(row_check(1'b1, 1'b0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(row_setup(-7, 9, 1, 2047, 1'b1));
    directed.push_back(row_step(1'b1));
    repeat (4) directed.push_back(row_step(1'b0));

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_SETUP) begin
        quiesce();
        set_regs(5'h1F, directed[i].cx, directed[i].cy, {1'b0, directed[i].rx},
                 {1'b0, directed[i].ry}, {11'b0, directed[i].fill});
      end else begin
        push_word(directed[i].restart, directed[i].kind == ROW_TYPED, directed[i].want_set,
                  directed[i].want);
      end
    end

    // Random walks: reprogram, usually restart, step to the end or part way, a few stray words
    while (words_sent < WORD_TARGET) begin
      quiet     = (words_sent > WORD_TARGET - QUIET_TAIL);
      gaps_on   = ($urandom_range(0, 2) != 0);
      stalls_on = ($urandom_range(0, 2) != 0);
      quiesce();
      rx_pick = pick_radius();
      ry_pick = pick_radius();
      mask    = $urandom_range(0, 1) ? 5'h1F : 5'($urandom_range(1, 31));
      set_regs(mask, 12'($urandom), 12'($urandom), {1'($urandom), rx_pick},
               {1'($urandom), ry_pick}, {11'($urandom), 1'($urandom)});
      if ($urandom_range(0, 7) == 0) push_word(1'b0, 1'b0, 1'b0, no_set);
      if ($urandom_range(0, 4) != 0) push_word(1'b1, 1'b0, 1'b0, no_set);
      cap = (rx_sq <= 144 && ry_sq <= 144) ? 200 : $urandom_range(5, 40);
      if ($urandom_range(0, 5) == 0) cap = $urandom_range(1, 4);
      n = 0;
      while (walking && n < cap) begin
        push_word(1'b0, 1'b0, 1'b0, no_set);
        n++;
      end
      repeat ($urandom_range(0, 2)) push_word(1'b0, 1'b0, 1'b0, no_set);
    end

    // Drain and let the block settle before judging
    in_ch.valid <= 1'b0;
    wait_left = STALL_LIMIT / 2;
    while (pending_sets.size() != 0 && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_sets.size() != 0)
      flag_mismatch($sformatf("%0d coordinate sets never arrived", pending_sets.size()));

    $display("run: %0d input words over %0d register setups, %0d walks to the last set",
             words_sent, setups, walks_done);
    $display("run: %0d coordinate sets checked, %0d mismatches", sets_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
